// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at the same clock edge, masked while reset is held.
`define R5RR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked at the following clock edge, masked while reset is held.
`define R5RR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/r5rr_pkg.sv -----
// ----------------------------------------------------------------------------
// r5rr_pkg
// Constants, codes and shared types of the RAID5 read and rebuild engine.
// ----------------------------------------------------------------------------
package r5rr_pkg;

  localparam int MAX_DISKS      = 8;
  localparam int WORDS_PER_DISK = 4096;

  localparam int DISK_W  = $clog2(MAX_DISKS);
  localparam int OFF_W   = $clog2(WORDS_PER_DISK);
  localparam int MEM_AW  = DISK_W + OFF_W;
  localparam int MEM_DEPTH = MAX_DISKS * WORDS_PER_DISK;

  localparam int DC_W    = 4;
  localparam int SB_W    = 13;
  localparam int ROWS_W  = 13;
  localparam int MASK_W  = 8;
  localparam int ADDR_W  = 32;
  localparam int WORD_W  = 32;
  localparam int REM_W   = SB_W - 1;
  localparam int CNT_W   = $clog2(ADDR_W + 1);
  localparam int PROD_W  = OFF_W + SB_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int POP_W   = $clog2(MASK_W + 1);

  // Packing of the input item's tdata, lowest field first.
  localparam int F_DISK_LO  = 0;
  localparam int F_WIDX_LO  = F_DISK_LO + 3;
  localparam int F_WVAL_LO  = F_WIDX_LO + 12;
  localparam int F_BADDR_LO = F_WVAL_LO + 32;
  localparam int IN_TDATA_W = ((F_BADDR_LO + 32 + 7) / 8) * 8;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    REG_DISK_COUNT    = 2'd0,
    REG_STRIPE_BLOCKS = 2'd1,
    REG_STRIPE_ROWS   = 2'd2,
    REG_PRESENT_MASK  = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_Y,
    ST_DIV_K,
    ST_ROW,
    ST_DIV_M,
    ST_SEL,
    ST_XOR,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    DIV_UNIT,
    DIV_ROW,
    DIV_ROT
  } div_kind_t;

  // Effective configuration after saturation and masking.
  typedef struct packed {
    logic [DC_W-1:0]   dc;
    logic [DISK_W-1:0] nd;
    logic [SB_W-1:0]   sb;
    logic [ROWS_W-1:0] rows;
    logic [MASK_W-1:0] mask;
    logic [POP_W-1:0]  cnt;
  } cfg_t;

  typedef struct packed {
    logic              mem_wr;
    logic              div_start;
    div_kind_t         div_kind;
    logic              map_en;
    logic              res_init;
    logic              res_avail;
    logic              rd_en;
    logic [DISK_W-1:0] rd_disk;
    logic              acc_en;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic              div_busy;
    logic              row_ok;
    logic              off_ok;
    logic              tgt_present;
    logic              can_rebuild;
    logic              out_free;
    logic [DISK_W-1:0] disk;
    logic [DISK_W-1:0] nd;
  } sts_t;

endpackage

// ----- hdl/r5rr_regs.sv -----
// ----------------------------------------------------------------------------
// r5rr_regs
// Configuration registers behind the APB port, with the derived array view.
// ----------------------------------------------------------------------------
module r5rr_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [r5rr_pkg::APB_AW-1:0]   cfg_paddr,
  input  logic [r5rr_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [r5rr_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  output r5rr_pkg::cfg_t                cfg
);

  logic [r5rr_pkg::DC_W-1:0]   dc_r;
  logic [r5rr_pkg::SB_W-1:0]   sb_r;
  logic [r5rr_pkg::ROWS_W-1:0] rows_r;
  logic [r5rr_pkg::MASK_W-1:0] mask_r;
  logic                        wr_en;
  r5rr_pkg::reg_idx_t          idx;
  logic [r5rr_pkg::DC_W-1:0]   dc_eff;
  logic [r5rr_pkg::MASK_W-1:0] mask_eff;
  logic [r5rr_pkg::POP_W-1:0]  pop;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign idx        = r5rr_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r   <= r5rr_pkg::DC_W'(3);
      sb_r   <= r5rr_pkg::SB_W'(1);
      rows_r <= '0;
      mask_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        r5rr_pkg::REG_DISK_COUNT:    dc_r   <= cfg_pwdata[r5rr_pkg::DC_W-1:0];
        r5rr_pkg::REG_STRIPE_BLOCKS: sb_r   <= cfg_pwdata[r5rr_pkg::SB_W-1:0];
        r5rr_pkg::REG_STRIPE_ROWS:   rows_r <= cfg_pwdata[r5rr_pkg::ROWS_W-1:0];
        r5rr_pkg::REG_PRESENT_MASK:  mask_r <= cfg_pwdata[r5rr_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      r5rr_pkg::REG_DISK_COUNT:    cfg_prdata = r5rr_pkg::APB_DW'(dc_r);
      r5rr_pkg::REG_STRIPE_BLOCKS: cfg_prdata = r5rr_pkg::APB_DW'(sb_r);
      r5rr_pkg::REG_STRIPE_ROWS:   cfg_prdata = r5rr_pkg::APB_DW'(rows_r);
      r5rr_pkg::REG_PRESENT_MASK:  cfg_prdata = r5rr_pkg::APB_DW'(mask_r);
      default:                     cfg_prdata = '0;
    endcase
  end

  // Disk count is held to the supported range; mask bits of unused disks drop out.
  always_comb begin
    if (dc_r < r5rr_pkg::DC_W'(2)) begin
      dc_eff = r5rr_pkg::DC_W'(2);
    end else if (dc_r > r5rr_pkg::DC_W'(r5rr_pkg::MAX_DISKS)) begin
      dc_eff = r5rr_pkg::DC_W'(r5rr_pkg::MAX_DISKS);
    end else begin
      dc_eff = dc_r;
    end
    pop = '0;
    for (int i = 0; i < r5rr_pkg::MASK_W; i++) begin
      mask_eff[i] = mask_r[i] && (r5rr_pkg::DC_W'(i) < dc_eff);
      pop = pop + r5rr_pkg::POP_W'(mask_eff[i]);
    end
  end

  assign cfg.dc   = dc_eff;
  assign cfg.nd   = r5rr_pkg::DISK_W'(dc_eff - r5rr_pkg::DC_W'(1));
  assign cfg.sb   = (sb_r == '0) ? r5rr_pkg::SB_W'(1) : sb_r;
  assign cfg.rows = rows_r;
  assign cfg.mask = mask_eff;
  assign cfg.cnt  = pop;

endmodule

// ----- hdl/r5rr_ctrl.sv -----
// ----------------------------------------------------------------------------
// r5rr_ctrl
// Sequencer for one item: load writes, divisions, row and offset checks, disk reads.
// ----------------------------------------------------------------------------
module r5rr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_acc,
  input  logic            in_op,
  output logic            in_ready,
  input  r5rr_pkg::sts_t  sts,
  output r5rr_pkg::cmd_t  cmd
);

  r5rr_pkg::state_t              state_r, state_nxt;
  logic [r5rr_pkg::DISK_W-1:0]   idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= r5rr_pkg::ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      r5rr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          if (in_op == r5rr_pkg::OP_READ) begin
            cmd.div_start = 1'b1;
            cmd.div_kind  = r5rr_pkg::DIV_UNIT;
            state_nxt     = r5rr_pkg::ST_DIV_Y;
          end else begin
            cmd.mem_wr = 1'b1;
          end
        end
      end
      r5rr_pkg::ST_DIV_Y: begin
        if (!sts.div_busy) begin
          cmd.div_start = 1'b1;
          cmd.div_kind  = r5rr_pkg::DIV_ROW;
          state_nxt     = r5rr_pkg::ST_DIV_K;
        end
      end
      r5rr_pkg::ST_DIV_K: begin
        if (!sts.div_busy) begin
          state_nxt = r5rr_pkg::ST_ROW;
        end
      end
      r5rr_pkg::ST_ROW: begin
        if (sts.row_ok) begin
          cmd.div_start = 1'b1;
          cmd.div_kind  = r5rr_pkg::DIV_ROT;
          state_nxt     = r5rr_pkg::ST_DIV_M;
        end else begin
          cmd.res_init = 1'b1;
          state_nxt    = r5rr_pkg::ST_DONE;
        end
      end
      r5rr_pkg::ST_DIV_M: begin
        if (!sts.div_busy) begin
          cmd.map_en = 1'b1;
          state_nxt  = r5rr_pkg::ST_SEL;
        end
      end
      r5rr_pkg::ST_SEL: begin
        cmd.res_init = 1'b1;
        if (!sts.off_ok) begin
          state_nxt = r5rr_pkg::ST_DONE;
        end else if (sts.tgt_present) begin
          cmd.res_avail = 1'b1;
          cmd.rd_en     = 1'b1;
          cmd.rd_disk   = sts.disk;
          cmd.acc_en    = 1'b1;
          state_nxt     = r5rr_pkg::ST_DRAIN;
        end else if (sts.can_rebuild) begin
          cmd.res_avail = 1'b1;
          idx_nxt       = '0;
          state_nxt     = r5rr_pkg::ST_XOR;
        end else begin
          state_nxt = r5rr_pkg::ST_DONE;
        end
      end
      r5rr_pkg::ST_XOR: begin
        // One disk read per cycle; the missing disk's slot is read but not folded in.
        cmd.rd_en   = 1'b1;
        cmd.rd_disk = idx_r;
        cmd.acc_en  = (idx_r != sts.disk);
        if (idx_r == sts.nd) begin
          state_nxt = r5rr_pkg::ST_DRAIN;
        end else begin
          idx_nxt = idx_r + r5rr_pkg::DISK_W'(1);
        end
      end
      r5rr_pkg::ST_DRAIN: begin
        state_nxt = r5rr_pkg::ST_DONE;
      end
      r5rr_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = r5rr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = r5rr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/r5rr_dp.sv -----
// ----------------------------------------------------------------------------
// r5rr_dp
// Datapath: disk store, bit-serial divider, address mapping, XOR accumulator
// and the result register.
// ----------------------------------------------------------------------------
module r5rr_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  r5rr_pkg::cfg_t                     cfg,
  input  r5rr_pkg::cmd_t                     cmd,
  output r5rr_pkg::sts_t                     sts,
  input  logic [r5rr_pkg::DISK_W-1:0]        in_disk,
  input  logic [r5rr_pkg::OFF_W-1:0]         in_widx,
  input  logic [r5rr_pkg::WORD_W-1:0]        in_wval,
  input  logic [r5rr_pkg::ADDR_W-1:0]        in_baddr,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [r5rr_pkg::WORD_W-1:0]        out_tdata,
  output logic                               out_tuser
);

  logic [r5rr_pkg::WORD_W-1:0] mem [r5rr_pkg::MEM_DEPTH];
  logic [r5rr_pkg::WORD_W-1:0] mem_q_r;
  logic [r5rr_pkg::MEM_AW-1:0] rd_addr;
  logic [r5rr_pkg::MEM_AW-1:0] wr_addr;

  // Divider: remainder, shifting dividend/quotient, divisor, step count.
  logic                        div_busy_r;
  logic [r5rr_pkg::CNT_W-1:0]  div_cnt_r;
  logic [r5rr_pkg::REM_W-1:0]  div_rem_r;
  logic [r5rr_pkg::ADDR_W-1:0] div_q_r;
  logic [r5rr_pkg::SB_W-1:0]   div_d_r;
  logic [r5rr_pkg::SB_W-1:0]   rem_sh;
  logic                        rem_ge;
  logic [r5rr_pkg::REM_W-1:0]  step_rem;
  logic [r5rr_pkg::ADDR_W-1:0] step_q;

  logic [r5rr_pkg::REM_W-1:0]  r_r;
  logic [r5rr_pkg::OFF_W-1:0]  k_r;
  logic [r5rr_pkg::DISK_W-1:0] ymod_r;
  logic [r5rr_pkg::DISK_W-1:0] kmod;
  logic [r5rr_pkg::PROD_W-1:0] prod_r;
  logic [r5rr_pkg::DISK_W-1:0] disk_r;
  logic [r5rr_pkg::DC_W-1:0]   rot_sum;
  logic [r5rr_pkg::DISK_W-1:0] disk_map;
  logic [r5rr_pkg::SUM_W-1:0]  off_sum;

  logic [r5rr_pkg::WORD_W-1:0] acc_r;
  logic                        avail_r;
  logic                        acc_d_r;
  logic                        out_tvalid_r;
  logic [r5rr_pkg::WORD_W-1:0] out_tdata_r;
  logic                        out_tuser_r;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh   = {div_rem_r, div_q_r[r5rr_pkg::ADDR_W-1]};
  assign rem_ge   = (rem_sh >= div_d_r);
  assign step_rem = rem_ge ? r5rr_pkg::REM_W'(rem_sh - div_d_r) : r5rr_pkg::REM_W'(rem_sh);
  assign step_q   = {div_q_r[r5rr_pkg::ADDR_W-2:0], rem_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
    end else if (div_busy_r && (div_cnt_r == r5rr_pkg::CNT_W'(1))) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_rem_r <= '0;
      case (cmd.div_kind)
        r5rr_pkg::DIV_UNIT: begin
          div_q_r   <= in_baddr;
          div_d_r   <= cfg.sb;
          div_cnt_r <= r5rr_pkg::CNT_W'(r5rr_pkg::ADDR_W);
        end
        r5rr_pkg::DIV_ROW: begin
          // Unit number stays in the shift register; keep the word within the unit.
          r_r       <= div_rem_r;
          div_d_r   <= r5rr_pkg::SB_W'(cfg.nd);
          div_cnt_r <= r5rr_pkg::CNT_W'(r5rr_pkg::ADDR_W);
        end
        r5rr_pkg::DIV_ROT: begin
          // The row has passed its check, so it fits in an offset's width.
          k_r       <= div_q_r[r5rr_pkg::OFF_W-1:0];
          ymod_r    <= div_rem_r[r5rr_pkg::DISK_W-1:0];
          div_q_r   <= {div_q_r[r5rr_pkg::OFF_W-1:0],
                        {(r5rr_pkg::ADDR_W - r5rr_pkg::OFF_W){1'b0}}};
          div_d_r   <= r5rr_pkg::SB_W'(cfg.dc);
          div_cnt_r <= r5rr_pkg::CNT_W'(r5rr_pkg::OFF_W);
        end
        default: begin
          div_cnt_r <= '0;
        end
      endcase
    end else if (div_busy_r) begin
      div_rem_r <= step_rem;
      div_q_r   <= step_q;
      div_cnt_r <= div_cnt_r - r5rr_pkg::CNT_W'(1);
    end
  end

  // Left-symmetric rotation: (nd - k mod dc + y mod nd + 1) mod dc, below 2*dc.
  assign kmod     = div_rem_r[r5rr_pkg::DISK_W-1:0];
  assign rot_sum  = r5rr_pkg::DC_W'(cfg.nd) + r5rr_pkg::DC_W'(1) - r5rr_pkg::DC_W'(kmod)
                  + r5rr_pkg::DC_W'(ymod_r);
  assign disk_map = (rot_sum >= cfg.dc) ? r5rr_pkg::DISK_W'(rot_sum - cfg.dc)
                                        : r5rr_pkg::DISK_W'(rot_sum);

  always_ff @(posedge clk) begin
    if (cmd.map_en) begin
      prod_r <= r5rr_pkg::PROD_W'(k_r) * r5rr_pkg::PROD_W'(cfg.sb);
      disk_r <= disk_map;
    end
  end

  assign off_sum = r5rr_pkg::SUM_W'(prod_r) + r5rr_pkg::SUM_W'(r_r);
  assign rd_addr = {cmd.rd_disk, off_sum[r5rr_pkg::OFF_W-1:0]};
  assign wr_addr = {in_disk, in_widx};

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[wr_addr] <= in_wval;
    end
    if (cmd.rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_d_r <= 1'b0;
    end else begin
      acc_d_r <= cmd.rd_en && cmd.acc_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_init) begin
      acc_r   <= '0;
      avail_r <= cmd.res_avail;
    end else if (acc_d_r) begin
      acc_r <= acc_r ^ mem_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tdata_r <= acc_r;
      out_tuser_r <= avail_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign sts.div_busy    = div_busy_r;
  // A row at or beyond the disk's word count can never give an offset inside the store.
  assign sts.row_ok      = (div_q_r < r5rr_pkg::ADDR_W'(cfg.rows)) &&
                           (div_q_r < r5rr_pkg::ADDR_W'(r5rr_pkg::WORDS_PER_DISK));
  assign sts.off_ok      = (off_sum < r5rr_pkg::SUM_W'(r5rr_pkg::WORDS_PER_DISK));
  assign sts.tgt_present = cfg.mask[disk_r];
  assign sts.can_rebuild = (cfg.cnt == r5rr_pkg::POP_W'(cfg.nd));
  assign sts.out_free    = !out_tvalid_r || out_tready;
  assign sts.disk        = disk_r;
  assign sts.nd          = cfg.nd;

endmodule

// ----- hdl/raid5_block_read_rebuild_core.sv -----
// ----------------------------------------------------------------------------
// raid5_block_read_rebuild_core
// RAID5 read engine with left-symmetric parity rotation and single-disk rebuild.
// ----------------------------------------------------------------------------
// A load item (tuser 0) writes one word into a disk's store, and the engine
// stays ready for the next item. A read item (tuser 1) is mapped to unit,
// row, disk and word offset by a shared bit-serial divider: two 32-step
// divisions and one 12-step division, one quotient bit per cycle, which set
// most of the time. A read whose row is out of range skips the last division
// and the disk reads; a rebuild reads every disk in turn, since the disk
// store has one read port and the XOR takes one disk per cycle. One item is
// worked on at a time; a finished result waits in the output register while
// the next item is accepted. Unavailable blocks return zero data with
// tuser 0. Words that were never loaded read as garbage.
module raid5_block_read_rebuild_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // disk_sel[2:0], word_index[14:3], word_value[46:15], block_address[78:47], 0
  input  logic [r5rr_pkg::IN_TDATA_W-1:0]    in_tdata,
  // op[0]
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // read_data[31:0]
  output logic [r5rr_pkg::WORD_W-1:0]        out_tdata,
  // available[0]
  output logic                               out_tuser,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [r5rr_pkg::APB_AW-1:0]        cfg_paddr,
  input  logic [r5rr_pkg::APB_DW-1:0]        cfg_pwdata,
  output logic [r5rr_pkg::APB_DW-1:0]        cfg_prdata,
  output logic                               cfg_pready
);

  r5rr_pkg::cfg_t cfg;
  r5rr_pkg::cmd_t cmd;
  r5rr_pkg::sts_t sts;
  logic           in_acc;

  assign in_acc = in_tvalid && in_tready;

  r5rr_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  r5rr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .in_op    (in_tuser),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  r5rr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .in_disk    (in_tdata[r5rr_pkg::F_DISK_LO +: r5rr_pkg::DISK_W]),
    .in_widx    (in_tdata[r5rr_pkg::F_WIDX_LO +: r5rr_pkg::OFF_W]),
    .in_wval    (in_tdata[r5rr_pkg::F_WVAL_LO +: r5rr_pkg::WORD_W]),
    .in_baddr   (in_tdata[r5rr_pkg::F_BADDR_LO +: r5rr_pkg::ADDR_W]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- hdl/r5rr_chk.sv -----
// ----------------------------------------------------------------------------
// r5rr_chk
// Port-level checker for the RAID5 read engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module r5rr_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [r5rr_pkg::WORD_W-1:0]     out_tdata,
  input logic                            out_tuser,
  input logic                            cfg_pready
);

  // A stalled result must hold still.
  `R5RR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // An unavailable block always carries zero data.
  `R5RR_ASSERT_NOW(a_unavail_zero, clk, rst_n, out_tvalid && !out_tuser, out_tdata == '0, "unavailable result with non-zero data")

  // A load item never produces a result.
  `R5RR_ASSERT_NEXT(a_load_silent, clk, rst_n, in_tvalid && in_tready && !in_tuser && !out_tvalid, !out_tvalid, "result appeared after a load item")

  // A read item occupies the engine, dropping the input's ready.
  `R5RR_ASSERT_NEXT(a_read_busy, clk, rst_n, in_tvalid && in_tready && in_tuser, !in_tready, "item taken right after a read item")

  `R5RR_ASSERT_NOW(a_pready, clk, rst_n, 1'b1, cfg_pready, "configuration port stalled")

endmodule

bind raid5_block_read_rebuild_core r5rr_chk u_chk (.*);
